/* design/tccw_pkg.sv */
package tccw_pkg;

  // Operation codes carried on the operation port.
  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_SET   = 3'd1,
    OP_MOVE  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // Character codes with special meaning to put-char.
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Tab stops fall on multiples of eight; the mask clears the low bits.
  localparam logic signed [9:0] TAB_STEP = 10'sd8;
  localparam logic signed [9:0] TAB_MASK = ~(TAB_STEP - 10'sd1);

  localparam logic [7:0]  ATTR_RESET  = 8'h0F;
  localparam logic [15:0] RESET_BLANK = {ATTR_RESET, CH_SPACE};

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic fill_write;
    logic scr_rd;
    logic scr_wr;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_clear;
    logic op_read;
    logic scroll;
    logic ptr_end;
    logic copy_end;
  } status_t;

endpackage

/* design/tccw_ctrl.sv */
module tccw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tccw_pkg::status_t  status,
  output tccw_pkg::cmd_t     cmd,
  output logic               busy
);

  tccw_pkg::state_t state;
  tccw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tccw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tccw_pkg::ST_INIT: begin
        if (status.ptr_end) state_next = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_IDLE: begin
        if (start) state_next = tccw_pkg::ST_EXEC;
      end
      tccw_pkg::ST_EXEC: begin
        if (status.op_clear) state_next = tccw_pkg::ST_FILL;
        else if (status.op_read) state_next = tccw_pkg::ST_RD_WAIT;
        else if (status.scroll) state_next = tccw_pkg::ST_SCR_RD;
        else state_next = tccw_pkg::ST_FINISH;
      end
      tccw_pkg::ST_RD_WAIT: begin
        state_next = tccw_pkg::ST_FINISH;
      end
      tccw_pkg::ST_SCR_RD: begin
        state_next = tccw_pkg::ST_SCR_WR;
      end
      tccw_pkg::ST_SCR_WR: begin
        if (status.copy_end) state_next = tccw_pkg::ST_FILL;
        else state_next = tccw_pkg::ST_SCR_RD;
      end
      tccw_pkg::ST_FILL: begin
        if (status.ptr_end) state_next = tccw_pkg::ST_FINISH;
      end
      tccw_pkg::ST_FINISH: begin
        state_next = tccw_pkg::ST_IDLE;
      end
      default: state_next = tccw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      tccw_pkg::ST_INIT:    cmd.fill_write = 1'b1;
      tccw_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      tccw_pkg::ST_EXEC:    cmd.exec = 1'b1;
      tccw_pkg::ST_RD_WAIT: cmd = '0;
      tccw_pkg::ST_SCR_RD:  cmd.scr_rd = 1'b1;
      tccw_pkg::ST_SCR_WR:  cmd.scr_wr = 1'b1;
      tccw_pkg::ST_FILL:    cmd.fill_write = 1'b1;
      tccw_pkg::ST_FINISH:  cmd.load_result = 1'b1;
      default:              cmd = '0;
    endcase
  end

endmodule

/* design/tccw_datapath.sv */
module tccw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  tccw_pkg::cmd_t     cmd,
  output tccw_pkg::status_t  status,
  input  logic [2:0]         operation,
  input  logic [7:0]         char_code,
  input  logic signed [7:0]  col_arg,
  input  logic signed [7:0]  row_arg,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data,
  output logic               done,
  output logic [6:0]         cursor_col,
  output logic [4:0]         cursor_row,
  output logic [10:0]        cursor_index,
  output logic [15:0]        cell_word
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);

  localparam logic signed [9:0] COLS_S = 10'(COLUMNS);
  localparam logic signed [9:0] ROWS_S = 10'(ROWS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

  logic [15:0] mem [CELLS];

  logic [2:0]        op_q;
  logic [7:0]        ch_q;
  logic signed [7:0] ca_q;
  logic signed [7:0] ra_q;
  logic [7:0]        attr;
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [AW-1:0]     ptr;
  logic [15:0]       fill_cell;
  logic [15:0]       rdata;
  logic              hit;

  // Operation evaluation
  logic signed [9:0] c_cur, r_cur, c_arg, r_arg;
  logic signed [9:0] put_c, put_r, put_wc;
  logic              put_we, put_scroll;
  logic [7:0]        put_char;
  logic signed [9:0] mv_c, mv_r;
  logic signed [9:0] set_c, set_r;
  logic              rd_hit;
  logic signed [9:0] new_c, new_r;
  logic [RW-1:0]     mul_row;
  logic [CW-1:0]     mul_col;
  logic [AW-1:0]     cell_addr;
  logic [AW-1:0]     cur_addr;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  logic [AW+10:0]    idx_ext;
  logic [CW+6:0]     col_ext;
  logic [RW+4:0]     row_ext;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q <= operation;
      ch_q <= char_code;
      ca_q <= col_arg;
      ra_q <= row_arg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tccw_pkg::ATTR_RESET;
    end else if (cfg_write) begin
      attr <= cfg_data;
    end
  end

  always_comb begin
    c_cur = 10'(cur_col);
    r_cur = 10'(cur_row);
    c_arg = 10'(ca_q);
    r_arg = 10'(ra_q);

    // Put-char: control codes, printable codes, wrap and scroll.
    put_c    = c_cur;
    put_r    = r_cur;
    put_wc   = c_cur;
    put_we   = 1'b0;
    put_char = ch_q;
    if (!ch_q[7]) begin
      if (ch_q == tccw_pkg::CH_BS) begin
        if (c_cur != 10'sd0) begin
          put_c    = c_cur - 10'sd1;
          put_wc   = c_cur - 10'sd1;
          put_we   = 1'b1;
          put_char = tccw_pkg::CH_SPACE;
        end else if (r_cur > 10'sd0) begin
          put_r = r_cur - 10'sd1;
        end
      end else if (ch_q == tccw_pkg::CH_TAB) begin
        put_c = (c_cur + tccw_pkg::TAB_STEP) & tccw_pkg::TAB_MASK;
      end else if (ch_q == tccw_pkg::CH_CR) begin
        put_c = 10'sd0;
      end else if (ch_q == tccw_pkg::CH_LF) begin
        put_c = 10'sd0;
        put_r = r_cur + 10'sd1;
      end else if (ch_q >= tccw_pkg::CH_SPACE) begin
        put_we = 1'b1;
        put_c  = c_cur + 10'sd1;
      end
    end
    if (put_c >= COLS_S) begin
      put_c = 10'sd0;
      put_r = put_r + 10'sd1;
    end
    put_scroll = (put_r >= ROWS_S);
    if (put_scroll) put_r = ROWS_S - 10'sd1;

    // Move by offset with edge wrap (column clamped where it cannot wrap), then clamp the row.
    mv_c = c_cur + c_arg;
    mv_r = r_cur + r_arg;
    if (mv_c < 10'sd0) begin
      if (mv_r > 10'sd0) begin
        mv_r = mv_r - 10'sd1;
        mv_c = COLS_S - 10'sd1;
      end else begin
        mv_c = 10'sd0;
      end
    end
    if (mv_c >= COLS_S) begin
      if (mv_r < ROWS_S - 10'sd1) begin
        mv_c = 10'sd0;
        mv_r = mv_r + 10'sd1;
      end else begin
        mv_c = COLS_S - 10'sd1;
      end
    end
    if (mv_r < 10'sd0) mv_r = 10'sd0;
    else if (mv_r > ROWS_S - 10'sd1) mv_r = ROWS_S - 10'sd1;

    // Set cursor with clamping.
    if (c_arg < 10'sd0) set_c = 10'sd0;
    else if (c_arg > COLS_S - 10'sd1) set_c = COLS_S - 10'sd1;
    else set_c = c_arg;
    if (r_arg < 10'sd0) set_r = 10'sd0;
    else if (r_arg > ROWS_S - 10'sd1) set_r = ROWS_S - 10'sd1;
    else set_r = r_arg;

    rd_hit = (c_arg >= 10'sd0) && (c_arg < COLS_S) && (r_arg >= 10'sd0) && (r_arg < ROWS_S);

    new_c = c_cur;
    new_r = r_cur;
    unique case (op_q)
      tccw_pkg::OP_PUT: begin
        new_c = put_c;
        new_r = put_r;
      end
      tccw_pkg::OP_SET: begin
        new_c = set_c;
        new_r = set_r;
      end
      tccw_pkg::OP_MOVE: begin
        new_c = mv_c;
        new_r = mv_r;
      end
      tccw_pkg::OP_CLEAR: begin
        new_c = 10'sd0;
        new_r = 10'sd0;
      end
      default: begin
        new_c = c_cur;
        new_r = r_cur;
      end
    endcase

    // One address multiplier serves both the put-char write and the read.
    if (op_q == tccw_pkg::OP_READ) begin
      mul_row = ra_q[RW-1:0];
      mul_col = ca_q[CW-1:0];
    end else begin
      mul_row = cur_row;
      mul_col = put_wc[CW-1:0];
    end
    cell_addr = AW'(mul_row * COLUMNS) + AW'(mul_col);
  end

  assign status.op_clear = (op_q == tccw_pkg::OP_CLEAR);
  assign status.op_read  = (op_q == tccw_pkg::OP_READ);
  assign status.scroll   = (op_q == tccw_pkg::OP_PUT) && put_scroll;
  assign status.ptr_end  = (ptr == LAST_CELL);
  assign status.copy_end = (ptr == LAST_COPY);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col   <= '0;
      cur_row   <= '0;
      ptr       <= '0;
      fill_cell <= tccw_pkg::RESET_BLANK;
    end else if (cmd.exec) begin
      cur_col   <= new_c[CW-1:0];
      cur_row   <= new_r[RW-1:0];
      ptr       <= '0;
      fill_cell <= {attr, tccw_pkg::CH_SPACE};
    end else if (cmd.fill_write || cmd.scr_wr) begin
      ptr <= ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) hit <= rd_hit;
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = fill_cell;
    if (cmd.exec) begin
      mem_we    = (op_q == tccw_pkg::OP_PUT) && put_we;
      mem_waddr = cell_addr;
      mem_wdata = {attr, put_char};
    end else if (cmd.fill_write) begin
      mem_we = 1'b1;
    end else if (cmd.scr_wr) begin
      mem_we    = 1'b1;
      mem_wdata = rdata;
    end
    mem_re    = (cmd.exec && (op_q == tccw_pkg::OP_READ) && rd_hit) || cmd.scr_rd;
    mem_raddr = cmd.scr_rd ? (ptr + ROW_STEP) : cell_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // Result registers.
  assign cur_addr = AW'(cur_row * COLUMNS) + AW'(cur_col);
  assign idx_ext  = {11'b0, cur_addr};
  assign col_ext  = {7'b0, cur_col};
  assign row_ext  = {5'b0, cur_row};

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      cursor_col   <= col_ext[6:0];
      cursor_row   <= row_ext[4:0];
      cursor_index <= idx_ext[10:0];
      cell_word    <= (status.op_read && hit) ? rdata : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.load_result;
    end
  end

endmodule

/* design/text_console_char_writer_top.sv */
// Text console character writer.
//
// The block keeps a screen of COLUMNS x ROWS 16-bit cells (attribute byte
// high, character byte low) in an internal memory, together with a cursor.
// An item is issued by raising start while busy is low; operation,
// char_code, col_arg and row_arg are sampled at that edge. Each item
// produces exactly one result, shown on cursor_col, cursor_row,
// cursor_index and cell_word for one cycle while done is high. The
// receiver cannot hold results off, so no result is ever waiting.
// From the accepting edge an item passes through the execute state, for a
// read a read-wait state for the registered memory data, and the finish
// state, which loads the result registers; done is then high in idle,
// where the next item can already be issued. A clear fills every cell
// with a blank in the current attribute before the finish state; a
// put-char that scrolls copies each cell one row up through the read port,
// reading it in the scroll-read state and writing it in the scroll-write
// state, and then blanks the bottom row.
// After reset the block writes the reset blank to every cell, one cell per
// cycle, with busy high until the last cell is written. The attribute
// register is written at any edge with cfg_write high, during that time too.
module text_console_char_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        operation,
  input  logic [7:0]        char_code,
  input  logic signed [7:0] col_arg,
  input  logic signed [7:0] row_arg,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  output logic              done,
  output logic [6:0]        cursor_col,
  output logic [4:0]        cursor_row,
  output logic [10:0]       cursor_index,
  output logic [15:0]       cell_word
);

  // Commands flow from the controller, status flows back.
  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t status;

  tccw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (operation),
    .char_code    (char_code),
    .col_arg      (col_arg),
    .row_arg      (row_arg),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .cursor_col   (cursor_col),
    .cursor_row   (cursor_row),
    .cursor_index (cursor_index),
    .cell_word    (cell_word)
  );

endmodule
